[rtl/jac_pkg.sv]
package jac_pkg;

    // Default width of a raw axis sample and of the load registers
    localparam int SAMPLE_BITS_DEF = 16;

    // Item kinds carried on the input tuser
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE       = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_CAPTURE      = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_BEGIN_RANGE  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_RANGE_SAMPLE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_CENTER_RANGE = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_LOAD         = 3'd5;

    // Calibration constants
    localparam int RANGE_HALF = 1000;
    localparam int FULL_SCALE = 32767;
    localparam int QUOT_BITS  = 15;   // magnitude bits of the position
    localparam int POS_BITS   = 16;
    localparam int OUT_BITS   = 17;
    localparam int OUT_TDATA_BITS = ((POS_BITS + 3 * OUT_BITS + 7) / 8) * 8;

    // Configuration register map
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;
    localparam logic [1:0] REG_LOAD_CENTER  = 2'd0;
    localparam logic [1:0] REG_LOAD_MINIMUM = 2'd1;
    localparam logic [1:0] REG_LOAD_MAXIMUM = 2'd2;

    localparam int LOAD_CENTER_RESET  = 0;
    localparam int LOAD_MINIMUM_RESET = -32768;
    localparam int LOAD_MAXIMUM_RESET = 32767;

endpackage

[rtl/joystick_axis_calibrator.sv]
// Joystick axis calibrator. Each request carries a kind on s_axis_tuser and a raw axis
// sample on s_axis_tdata, and produces exactly one result on m_axis: the calibrated
// position (nonzero only for a sample request) followed by the calibration center,
// minimum and maximum as they stand after the request, each 17 bits. A sample maps to
// a position in -32767..32767 (32767 stands for 1.0): the offset from center times
// 32767, divided by max - center above center or center - min below it, truncated
// toward zero and clamped; an offset of zero or a zero span on that side gives 0.
// The other kinds capture the center, begin a range capture (minimum at center + 1000,
// maximum at center - 1000), widen min/max, set the center to the midpoint of min and
// max, or load the three APB registers (load_center at 0x0, load_minimum at 0x4,
// load_maximum at 0x8; write them only while the block is idle). The block takes one
// request at a time: s_axis_tready is high only in the idle state. A sample request
// forms offset and span, then their magnitudes, loads the shift-subtract divider,
// runs sixteen divider steps (one saturation check, fifteen quotient bits), takes the
// quotient and then fills the result register. A sample whose quotient saturates
// ends after the saturation check. A sample that resolves to zero without division,
// and every other kind, goes from the execute step straight to the result register.
// The next request can be accepted in the cycle after the result is registered. A
// finished result waits in the output register; the next request is accepted
// meanwhile and holds in its last cycle until that register is free.
module joystick_axis_calibrator #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,  // raw_value
    input  logic [jac_pkg::KIND_BITS-1:0]        i_s_axis_tuser,  // kind
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // position[15:0], center_now[32:16], minimum_now[49:33], maximum_now[66:50]
    output logic [jac_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [jac_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [jac_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [jac_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    localparam int STATE_BITS = SAMPLE_BITS + 1;
    localparam int WIDE_BITS  = STATE_BITS + 1;   // offsets and spans
    localparam int EXT_BITS   = (STATE_BITS > jac_pkg::OUT_BITS) ? STATE_BITS
                                                                 : jac_pkg::OUT_BITS;
    localparam int OB = jac_pkg::OUT_BITS;
    localparam int PB = jac_pkg::POS_BITS;
    localparam int QB = jac_pkg::QUOT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ABS,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [jac_pkg::KIND_BITS-1:0] r_kind;
    logic signed [SAMPLE_BITS-1:0] r_raw;
    logic signed [STATE_BITS-1:0]  r_cal_center;
    logic signed [STATE_BITS-1:0]  r_cal_minimum;
    logic signed [STATE_BITS-1:0]  r_cal_maximum;
    logic signed [WIDE_BITS-1:0]   r_offset;
    logic signed [WIDE_BITS-1:0]   r_span;
    logic [WIDE_BITS-1:0]          r_offset_mag;
    logic [WIDE_BITS-1:0]          r_span_mag;
    logic                          r_neg;
    logic                          r_div_start;
    logic signed [PB-1:0]          r_pos;
    logic                          r_out_valid;
    logic [jac_pkg::OUT_TDATA_BITS-1:0] r_out_data;

    logic signed [SAMPLE_BITS-1:0] w_load_center;
    logic signed [SAMPLE_BITS-1:0] w_load_minimum;
    logic signed [SAMPLE_BITS-1:0] w_load_maximum;
    logic                          w_div_done;
    logic [QB-1:0]                 w_quot;

    logic                          w_in_accept;
    logic                          w_out_free;
    logic signed [STATE_BITS-1:0]  w_raw_ext;
    logic signed [WIDE_BITS-1:0]   w_offset;
    logic signed [WIDE_BITS-1:0]   w_span_hi;
    logic signed [WIDE_BITS-1:0]   w_span_lo;
    logic                          w_use_hi;
    logic                          w_use_lo;
    logic signed [STATE_BITS:0]    w_mid_sum;
    logic signed [STATE_BITS:0]    w_mid;
    logic signed [PB-1:0]          w_quot_ext;
    logic signed [EXT_BITS-1:0]    w_center_ext;
    logic signed [EXT_BITS-1:0]    w_minimum_ext;
    logic signed [EXT_BITS-1:0]    w_maximum_ext;

    jac_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_load_center  (w_load_center),
        .o_load_minimum (w_load_minimum),
        .o_load_maximum (w_load_maximum)
    );

    jac_div #(
        .MAG_BITS (WIDE_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_start),
        .i_offset (r_offset_mag),
        .i_span   (r_span_mag),
        .o_done   (w_div_done),
        .o_quot   (w_quot)
    );

    assign pready = 1'b1;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    // Offset and the span on the side of the sample
    assign w_raw_ext = STATE_BITS'(r_raw);
    assign w_offset  = WIDE_BITS'(r_raw) - WIDE_BITS'(r_cal_center);
    assign w_span_hi = WIDE_BITS'(r_cal_maximum) - WIDE_BITS'(r_cal_center);
    assign w_span_lo = WIDE_BITS'(r_cal_center) - WIDE_BITS'(r_cal_minimum);
    assign w_use_hi  = !w_offset[WIDE_BITS-1] && (w_offset != '0)
                       && (r_cal_maximum != r_cal_center);
    assign w_use_lo  = w_offset[WIDE_BITS-1] && (r_cal_minimum != r_cal_center);

    // Midpoint, truncated toward zero: add the sign bit before the shift
    assign w_mid_sum = (STATE_BITS + 1)'(r_cal_minimum) + (STATE_BITS + 1)'(r_cal_maximum);
    assign w_mid     = (w_mid_sum + (STATE_BITS + 1)'({1'b0, w_mid_sum[STATE_BITS]})) >>> 1;

    assign w_quot_ext = PB'({1'b0, w_quot});

    // State fields on the bus: sign-extend or truncate to 17 bits
    assign w_center_ext  = EXT_BITS'(r_cal_center);
    assign w_minimum_ext = EXT_BITS'(r_cal_minimum);
    assign w_maximum_ext = EXT_BITS'(r_cal_maximum);

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_div_start   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cal_center  <= '0;
            r_cal_minimum <= '0;
            r_cal_maximum <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_kind  <= i_s_axis_tuser;
                        r_raw   <= i_s_axis_tdata[SAMPLE_BITS-1:0];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_pos   <= '0;
                    r_state <= S_DONE;
                    unique case (r_kind)
                        jac_pkg::KIND_SAMPLE: begin
                            // go to the divider only when a span applies
                            r_offset <= w_offset;
                            r_span   <= w_use_hi ? w_span_hi : w_span_lo;
                            if (w_use_hi || w_use_lo) begin
                                r_state <= S_ABS;
                            end
                        end
                        jac_pkg::KIND_CAPTURE: begin
                            r_cal_center <= w_raw_ext;
                        end
                        jac_pkg::KIND_BEGIN_RANGE: begin
                            r_cal_minimum <= r_cal_center + STATE_BITS'(jac_pkg::RANGE_HALF);
                            r_cal_maximum <= r_cal_center - STATE_BITS'(jac_pkg::RANGE_HALF);
                        end
                        jac_pkg::KIND_RANGE_SAMPLE: begin
                            if (w_raw_ext < r_cal_minimum) begin
                                r_cal_minimum <= w_raw_ext;
                            end
                            if (w_raw_ext > r_cal_maximum) begin
                                r_cal_maximum <= w_raw_ext;
                            end
                        end
                        jac_pkg::KIND_CENTER_RANGE: begin
                            r_cal_center <= w_mid[STATE_BITS-1:0];
                        end
                        jac_pkg::KIND_LOAD: begin
                            r_cal_center  <= STATE_BITS'(w_load_center);
                            r_cal_minimum <= STATE_BITS'(w_load_minimum);
                            r_cal_maximum <= STATE_BITS'(w_load_maximum);
                        end
                        default: ;  // unused kinds leave the calibration alone
                    endcase
                end
                S_ABS: begin
                    // magnitudes for the divider; the sign is applied afterwards
                    r_offset_mag <= r_offset[WIDE_BITS-1] ? -r_offset : r_offset;
                    r_span_mag   <= r_span[WIDE_BITS-1] ? -r_span : r_span;
                    r_neg        <= r_offset[WIDE_BITS-1] ^ r_span[WIDE_BITS-1];
                    r_div_start  <= 1'b1;
                    r_state      <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_pos   <= r_neg ? -w_quot_ext : w_quot_ext;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= jac_pkg::OUT_TDATA_BITS'({w_maximum_ext[OB-1:0],
                                                                 w_minimum_ext[OB-1:0],
                                                                 w_center_ext[OB-1:0],
                                                                 r_pos});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

[rtl/jac_regs.sv]
module jac_regs #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [jac_pkg::PADDR_BITS-1:0]    i_paddr,
    input  logic [jac_pkg::PDATA_BITS-1:0]    i_pwdata,
    output logic [jac_pkg::PDATA_BITS-1:0]    o_prdata,
    output logic signed [SAMPLE_BITS-1:0]     o_load_center,
    output logic signed [SAMPLE_BITS-1:0]     o_load_minimum,
    output logic signed [SAMPLE_BITS-1:0]     o_load_maximum
);

    logic signed [SAMPLE_BITS-1:0] r_load_center;
    logic signed [SAMPLE_BITS-1:0] r_load_minimum;
    logic signed [SAMPLE_BITS-1:0] r_load_maximum;
    logic [1:0]                    w_index;

    assign w_index = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_center  <= SAMPLE_BITS'(jac_pkg::LOAD_CENTER_RESET);
            r_load_minimum <= SAMPLE_BITS'(jac_pkg::LOAD_MINIMUM_RESET);
            r_load_maximum <= SAMPLE_BITS'(jac_pkg::LOAD_MAXIMUM_RESET);
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (w_index)
                jac_pkg::REG_LOAD_CENTER:  r_load_center  <= i_pwdata[SAMPLE_BITS-1:0];
                jac_pkg::REG_LOAD_MINIMUM: r_load_minimum <= i_pwdata[SAMPLE_BITS-1:0];
                jac_pkg::REG_LOAD_MAXIMUM: r_load_maximum <= i_pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back sign-extended
    always_comb begin
        unique case (w_index)
            jac_pkg::REG_LOAD_CENTER:  o_prdata = jac_pkg::PDATA_BITS'(r_load_center);
            jac_pkg::REG_LOAD_MINIMUM: o_prdata = jac_pkg::PDATA_BITS'(r_load_minimum);
            jac_pkg::REG_LOAD_MAXIMUM: o_prdata = jac_pkg::PDATA_BITS'(r_load_maximum);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_load_center  = r_load_center;
    assign o_load_minimum = r_load_minimum;
    assign o_load_maximum = r_load_maximum;

endmodule

[rtl/jac_div.sv]
module jac_div #(
    parameter int MAG_BITS = jac_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [MAG_BITS-1:0]            i_offset,
    input  logic [MAG_BITS-1:0]            i_span,
    output logic                           o_done,
    output logic [jac_pkg::QUOT_BITS-1:0]  o_quot
);

    localparam int QB      = jac_pkg::QUOT_BITS;
    localparam int NB      = MAG_BITS + QB;
    localparam int CNT_BITS = $clog2(QB + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state;
    logic [NB-1:0]       r_rem;
    logic [NB-1:0]       r_dsh;
    logic [CNT_BITS-1:0] r_cnt;
    logic [QB-1:0]       r_quot;
    logic                r_done;

    logic [NB:0]         w_diff;
    logic                w_ge;
    logic [NB-1:0]       w_scaled;

    // Shared subtractor: trial remainder against the shifted span
    assign w_diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_ge   = !w_diff[NB];

    // offset * 32767 as (offset << 15) - offset
    assign w_scaled = (NB'(i_offset) << QB) - NB'(i_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= w_scaled;
                        r_dsh   <= NB'(i_span) << QB;
                        r_cnt   <= CNT_BITS'(QB);
                        r_quot  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == CNT_BITS'(QB)) begin
                        // quotient of 2^15 or more: saturate
                        if (w_ge) begin
                            r_quot  <= '1;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (w_ge) begin
                            r_rem <= w_diff[NB-1:0];
                        end
                        r_quot <= {r_quot[QB-2:0], w_ge};
                        if (r_cnt == '0) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[sim/joystick_axis_calibrator_tb.sv]
`timescale 1ns / 1ps

module joystick_axis_calibrator_tb;

    // Kinds the block must ignore: state held, position zero
    localparam logic [jac_pkg::KIND_BITS-1:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [jac_pkg::KIND_BITS-1:0] KIND_UNUSED_7 = 3'd7;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int BATCH_ITEMS   = 130;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic signed [jac_pkg::POS_BITS-1:0] position;
        logic signed [jac_pkg::OUT_BITS-1:0] center;
        logic signed [jac_pkg::OUT_BITS-1:0] minimum;
        logic signed [jac_pkg::OUT_BITS-1:0] maximum;
    } t_cal_result;

    // Scoreboard: tracks the calibration state and the results still owed by the block
    class t_calibration_tracker;
        logic signed [jac_pkg::OUT_BITS-1:0] cal_center;
        logic signed [jac_pkg::OUT_BITS-1:0] cal_minimum;
        logic signed [jac_pkg::OUT_BITS-1:0] cal_maximum;
        logic signed [15:0]         load_center;
        logic signed [15:0]         load_minimum;
        logic signed [15:0]         load_maximum;
        t_cal_result                expected_results[$];
        int                         mismatches;
        int                         results_checked;
        int                         kind_count[8];

        function new();
            cal_center      = '0;
            cal_minimum     = '0;
            cal_maximum     = '0;
            load_center     = 16'(jac_pkg::LOAD_CENTER_RESET);
            load_minimum    = 16'(jac_pkg::LOAD_MINIMUM_RESET);
            load_maximum    = 16'(jac_pkg::LOAD_MAXIMUM_RESET);
            mismatches      = 0;
            results_checked = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void set_load(logic [1:0] idx, logic signed [15:0] value);
            case (idx)
                jac_pkg::REG_LOAD_CENTER:  load_center  = value;
                jac_pkg::REG_LOAD_MINIMUM: load_minimum = value;
                jac_pkg::REG_LOAD_MAXIMUM: load_maximum = value;
                default: ;
            endcase
        endfunction

        // Offset from center scaled by the span on its side, truncated and clamped
        function logic signed [jac_pkg::POS_BITS-1:0] calibrate_position(
                logic signed [15:0] raw);
            longint offset;
            longint span;
            longint quot;
            offset = longint'(raw) - longint'(cal_center);
            if (offset > 0 && cal_maximum != cal_center)
                span = longint'(cal_maximum) - longint'(cal_center);
            else if (offset < 0 && cal_minimum != cal_center)
                span = longint'(cal_center) - longint'(cal_minimum);
            else
                return '0;
            quot = (offset * jac_pkg::FULL_SCALE) / span;
            if (quot > jac_pkg::FULL_SCALE)  quot = jac_pkg::FULL_SCALE;
            if (quot < -jac_pkg::FULL_SCALE) quot = -jac_pkg::FULL_SCALE;
            return 16'(quot);
        endfunction

        function void note_request(logic [jac_pkg::KIND_BITS-1:0] kind,
                                   logic signed [15:0] raw);
            t_cal_result exp_res;
            longint      mid;
            exp_res.position = '0;
            kind_count[kind]++;
            case (kind)
                jac_pkg::KIND_SAMPLE:  exp_res.position = calibrate_position(raw);
                jac_pkg::KIND_CAPTURE: cal_center = raw;
                jac_pkg::KIND_BEGIN_RANGE: begin
                    cal_minimum = 17'(longint'(cal_center) + jac_pkg::RANGE_HALF);
                    cal_maximum = 17'(longint'(cal_center) - jac_pkg::RANGE_HALF);
                end
                jac_pkg::KIND_RANGE_SAMPLE: begin
                    if (raw < cal_minimum) cal_minimum = raw;
                    if (raw > cal_maximum) cal_maximum = raw;
                end
                jac_pkg::KIND_CENTER_RANGE: begin
                    mid = (longint'(cal_minimum) + longint'(cal_maximum)) / 2;
                    cal_center = 17'(mid);
                end
                jac_pkg::KIND_LOAD: begin
                    cal_center  = load_center;
                    cal_minimum = load_minimum;
                    cal_maximum = load_maximum;
                end
                default: ;
            endcase
            exp_res.center  = cal_center;
            exp_res.minimum = cal_minimum;
            exp_res.maximum = cal_maximum;
            expected_results.push_back(exp_res);
        endfunction

        function void check_result(logic [jac_pkg::OUT_TDATA_BITS-1:0] tdata);
            t_cal_result                         exp_res;
            logic signed [jac_pkg::POS_BITS-1:0] got_pos;
            logic signed [jac_pkg::OUT_BITS-1:0] got_center;
            logic signed [jac_pkg::OUT_BITS-1:0] got_min;
            logic signed [jac_pkg::OUT_BITS-1:0] got_max;
            got_pos    = tdata[jac_pkg::POS_BITS-1:0];
            got_center = tdata[jac_pkg::POS_BITS +: jac_pkg::OUT_BITS];
            got_min    = tdata[jac_pkg::POS_BITS + jac_pkg::OUT_BITS +: jac_pkg::OUT_BITS];
            got_max    = tdata[jac_pkg::POS_BITS + 2 * jac_pkg::OUT_BITS +: jac_pkg::OUT_BITS];
            if (expected_results.size() == 0) begin
                $error("result with none expected: tdata %h", tdata);
                mismatches++;
                return;
            end
            exp_res = expected_results.pop_front();
            results_checked++;
            if (got_pos !== exp_res.position) begin
                $error("position: expected %0d, got %0d", exp_res.position, got_pos);
                mismatches++;
            end
            if (got_center !== exp_res.center) begin
                $error("center_now: expected %0d, got %0d", exp_res.center, got_center);
                mismatches++;
            end
            if (got_min !== exp_res.minimum) begin
                $error("minimum_now: expected %0d, got %0d", exp_res.minimum, got_min);
                mismatches++;
            end
            if (got_max !== exp_res.maximum) begin
                $error("maximum_now: expected %0d, got %0d", exp_res.maximum, got_max);
                mismatches++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n         = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [15:0]                        i_s_axis_tdata  = '0;   // raw_value
    logic [jac_pkg::KIND_BITS-1:0]      i_s_axis_tuser  = '0;   // kind
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // position[15:0], center_now[32:16], minimum_now[49:33], maximum_now[66:50]
    logic [jac_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                               psel            = 1'b0;
    logic                               penable         = 1'b0;
    logic                               pwrite          = 1'b0;
    logic [jac_pkg::PADDR_BITS-1:0]     paddr           = '0;
    logic [jac_pkg::PDATA_BITS-1:0]     pwdata          = '0;
    logic [jac_pkg::PDATA_BITS-1:0]     prdata;
    logic                               pready;

    t_calibration_tracker tracker;
    logic  calm       = 1'b0;   // no idling on either side while set
    logic  hold_arm   = 1'b0;   // ask the result side for one long hold-off
    logic  hold_taken = 1'b0;
    int    hold_left  = 0;
    int    cycle_count;
    int    requests_sent = 0;
    int    reg_writes    = 0;
    int    settings_used = 0;

    joystick_axis_calibrator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result side: check every accepted result, then pick the next tready.
    // The hold-off is counted here so that the request side keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata);
        if (hold_arm && !hold_taken) begin
            hold_taken      <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (calm) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= 19);
        end
    end

    // Abort a hung run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one request and hold it until accepted. Leave tvalid high on return
    // so that back-to-back requests never lower and raise it in one step.
    task automatic send_request(input logic [jac_pkg::KIND_BITS-1:0] kind,
                                input logic [15:0] raw);
        int gap;
        if (!calm && $urandom_range(99) < 19) begin
            gap = $urandom_range(1, 4);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= raw;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_request(kind, raw);
        requests_sent++;
    endtask

    // Drop tvalid, wait for every owed result, then let the pipeline drain
    task automatic settle_idle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_load_reg(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{value[15]}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_load(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] center, input logic [15:0] minimum,
                                 input logic [15:0] maximum);
        write_load_reg(jac_pkg::REG_LOAD_CENTER,  center);
        write_load_reg(jac_pkg::REG_LOAD_MINIMUM, minimum);
        write_load_reg(jac_pkg::REG_LOAD_MAXIMUM, maximum);
        settings_used++;
    endtask

    // Mostly uniform raw values, with extremes and values right around the center
    function automatic logic [15:0] pick_raw();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 16'h8000;
        else if (roll < 16)
            return 16'h7FFF;
        else if (roll < 30)
            return tracker.cal_center[15:0] + 16'($urandom_range(8)) - 16'd4;
        return 16'($urandom);
    endfunction

    // Extremes of the fields, every kind, zero and wrong-sign spans, truncation
    task automatic run_directed();
        send_request(jac_pkg::KIND_SAMPLE,       16'h1234);   // all-zero state: zero span
        send_request(jac_pkg::KIND_SAMPLE,       16'h8000);
        send_request(KIND_UNUSED_6,              16'hFFFF);
        send_request(KIND_UNUSED_7,              16'h7FFF);
        send_request(jac_pkg::KIND_CAPTURE,      16'd100);
        send_request(jac_pkg::KIND_BEGIN_RANGE,  16'h5A5A);   // span of the wrong sign
        send_request(jac_pkg::KIND_SAMPLE,       16'd600);
        send_request(jac_pkg::KIND_SAMPLE,       16'h8000);
        send_request(jac_pkg::KIND_RANGE_SAMPLE, 16'h7FFF);
        send_request(jac_pkg::KIND_RANGE_SAMPLE, 16'h8000);
        send_request(jac_pkg::KIND_CENTER_RANGE, 16'h0000);   // midpoint -0.5 truncates to 0
        send_request(jac_pkg::KIND_SAMPLE,       16'h0000);   // sample equal to center
        send_request(jac_pkg::KIND_SAMPLE,       16'h7FFF);
        send_request(jac_pkg::KIND_SAMPLE,       16'h8000);
        send_request(jac_pkg::KIND_LOAD,         16'hA5A5);   // reset register values
        send_request(jac_pkg::KIND_SAMPLE,       16'd16383);
        send_request(jac_pkg::KIND_SAMPLE,       16'hFFFF);
        send_request(jac_pkg::KIND_CAPTURE,      16'h8000);
        send_request(jac_pkg::KIND_BEGIN_RANGE,  16'h0000);
        send_request(jac_pkg::KIND_SAMPLE,       16'h7FFF);   // huge offset, negative span
        send_request(jac_pkg::KIND_RANGE_SAMPLE, 16'h7FFF);
        send_request(jac_pkg::KIND_SAMPLE,       16'h7FFF);
        send_request(jac_pkg::KIND_CAPTURE,      16'h7FFF);
        send_request(jac_pkg::KIND_BEGIN_RANGE,  16'h0000);   // state beyond the sample range
        send_request(jac_pkg::KIND_CENTER_RANGE, 16'h0000);
    endtask

    // Mostly complete calibration passes followed by samples; the rest is noise
    task automatic run_batch(input int count);
        int stop_at;
        int n;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(1))
                    send_request(jac_pkg::KIND_CAPTURE, pick_raw());
                else
                    send_request(jac_pkg::KIND_LOAD, pick_raw());
                if ($urandom_range(3) != 0) begin
                    send_request(jac_pkg::KIND_BEGIN_RANGE, pick_raw());
                    n = $urandom_range(2, 6);
                    repeat (n) send_request(jac_pkg::KIND_RANGE_SAMPLE, pick_raw());
                    if ($urandom_range(1))
                        send_request(jac_pkg::KIND_CENTER_RANGE, pick_raw());
                end
                n = $urandom_range(3, 10);
                repeat (n) send_request(jac_pkg::KIND_SAMPLE, pick_raw());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_request(3'($urandom_range(7)), pick_raw());
            end
        end
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        settle_idle();

        // Full range with the center at the bottom
        apply_setting(16'h8000, 16'h8000, 16'h7FFF);
        run_batch(BATCH_ITEMS);
        settle_idle();

        // Center at the top; run without any idling
        apply_setting(16'h7FFF, 16'h8000, 16'h7FFF);
        calm <= 1'b1;
        run_batch(BATCH_ITEMS);
        calm <= 1'b0;
        settle_idle();

        // Zero spans on both sides
        apply_setting(16'h0000, 16'h0000, 16'h0000);
        run_batch(BATCH_ITEMS);
        settle_idle();

        // Inverted range; stall the result side long enough to back up requests
        apply_setting(16'h7FFF, 16'h7FFF, 16'h8000);
        hold_arm <= 1'b1;
        run_batch(BATCH_ITEMS);
        settle_idle();

        repeat (2) begin
            apply_setting(16'($urandom), 16'($urandom), 16'($urandom));
            run_batch(BATCH_ITEMS);
            settle_idle();
        end

        $display("Sent %0d requests: %0d samples, %0d range samples, %0d captures, %0d loads",
                 requests_sent, tracker.kind_count[jac_pkg::KIND_SAMPLE],
                 tracker.kind_count[jac_pkg::KIND_RANGE_SAMPLE],
                 tracker.kind_count[jac_pkg::KIND_CAPTURE],
                 tracker.kind_count[jac_pkg::KIND_LOAD]);
        $display("Checked %0d results over %0d load settings (%0d register writes)",
                 tracker.results_checked, settings_used, reg_writes);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
